// ===== rtl/core/kss_pkg.sv =====
// shared types and constants for the k-th smallest select unit
`default_nettype none
package kss_pkg;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned RANK_W = 11;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [RANK_W-1:0] rank_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_START,
    ST_RANGE,
    ST_PIV_RD,
    ST_PIV_WT,
    ST_I_RD,
    ST_I_WT,
    ST_I_CMP,
    ST_J_RD,
    ST_J_WT,
    ST_J_CMP,
    ST_SWAP_I,
    ST_SWAP_J,
    ST_NARROW,
    ST_FIN_RD,
    ST_FIN_WT,
    ST_OUT
  } kss_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // write input element at fill count
    logic start;      // set lo, hi, k for a fresh selection
    logic rd_pivot;   // read store at middle of range
    logic cap_pivot;  // latch pivot from read data
    logic init_ij;    // i = lo - 1, j = hi + 1
    logic rd_i;       // i++ and read store at i
    logic cap_i;      // latch read data as element i
    logic rd_j;       // j-- and read store at j
    logic cap_j;      // latch read data as element j
    logic wr_i;       // store[i] = element j
    logic wr_j;       // store[j] = element i
    logic narrow;     // keep the side that holds rank k
    logic rd_lo;      // read store at lo
    logic cap_res;    // latch result from read data
    logic err_res;    // result is rank error
    logic clr_fill;   // restart the set
  } kss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rank_bad;   // k is zero or above the fill count after this element
    logic range_open; // lo < hi
    logic i_less;     // element i below pivot
    logic j_more;     // element j above pivot
    logic i_lt_j;     // i < j
  } kss_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/kss_stream_if.sv =====
// valid/ready channel interfaces for input and result transfers
`default_nettype none
interface kss_in_if;
  logic in_valid;
  logic in_ready;
  kss_pkg::data_t in_value;
  logic in_last;
  modport source (output in_valid, output in_value, output in_last, input in_ready);
  modport sink (input in_valid, input in_value, input in_last, output in_ready);
endinterface

interface kss_out_if;
  logic out_valid;
  logic out_ready;
  kss_pkg::data_t out_selected;
  logic out_rank_error;
  modport source (output out_valid, output out_selected, output out_rank_error,
                  input out_ready);
  modport sink (input out_valid, input out_selected, input out_rank_error,
                output out_ready);
endinterface
`default_nettype wire

// ===== rtl/core/kss_ram.sv =====
// generic single-port ram with registered read
`default_nettype none
module kss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/kss_datapath.sv =====
// index registers, pivot and element latches, and element store for selection
`default_nettype none
module kss_datapath #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire kss_pkg::kss_cmd_t cmd,
  output      kss_pkg::kss_sts_t sts,
  input  wire kss_pkg::data_t   in_value,
  input  wire kss_pkg::rank_t   k_rank,
  output      kss_pkg::data_t   res_value
);
  import kss_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  // fill count holds 0 .. DEPTH, signed indices hold -1 .. DEPTH
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = CW + 1;
  localparam int unsigned KW = (RANK_W > CW) ? RANK_W : CW;

  logic [CW-1:0] fill_r, fill_nxt;
  logic signed [IW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [KW-1:0] k_r, k_nxt;
  data_t pivot_r, ei_r, ej_r, res_r;
  logic signed [IW:0] mid_sum;
  logic signed [IW-1:0] left;
  logic [AW-1:0] addr;
  logic we;
  data_t wdata, rdata;

  assign mid_sum = IW'(0) + {lo_r[IW-1], lo_r} + {hi_r[IW-1], hi_r};
  assign left    = j_r - lo_r + IW'(1);

  always_comb begin
    addr  = fill_r[AW-1:0];
    we    = 1'b0;
    wdata = in_value;
    if (cmd.load) begin
      we = (fill_r < CW'(DEPTH));
    end else if (cmd.rd_pivot) begin
      addr = mid_sum[AW:1];
    end else if (cmd.rd_i) begin
      addr = AW'(i_r + IW'(1));
    end else if (cmd.rd_j) begin
      addr = AW'(j_r - IW'(1));
    end else if (cmd.wr_i) begin
      addr  = AW'(i_r);
      we    = 1'b1;
      wdata = ej_r;
    end else if (cmd.wr_j) begin
      addr  = AW'(j_r);
      we    = 1'b1;
      wdata = ei_r;
    end else if (cmd.rd_lo) begin
      addr = AW'(lo_r);
    end
  end

  kss_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store (
    .clk  (clk),
    .we   (we),
    .addr (addr),
    .wdata(wdata),
    .rdata(rdata)
  );

  always_comb begin
    fill_nxt = fill_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    if (cmd.load && fill_r < CW'(DEPTH)) begin
      fill_nxt = fill_r + CW'(1);
    end
    if (cmd.clr_fill) begin
      fill_nxt = '0;
    end
    if (cmd.start) begin
      lo_nxt = '0;
      hi_nxt = IW'({1'b0, fill_r}) - IW'(1);
      k_nxt  = KW'(k_rank);
    end
    if (cmd.init_ij) begin
      i_nxt = lo_r - IW'(1);
      j_nxt = hi_r + IW'(1);
    end
    if (cmd.rd_i) begin
      i_nxt = i_r + IW'(1);
    end
    if (cmd.rd_j) begin
      j_nxt = j_r - IW'(1);
    end
    if (cmd.narrow) begin
      if ({{(KW+1-IW){1'b0}}, k_r} <= (KW+1)'(left)) begin
        hi_nxt = j_r;
      end else begin
        k_nxt  = k_r - KW'(left);
        lo_nxt = j_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    i_r  <= i_nxt;
    j_r  <= j_nxt;
    k_r  <= k_nxt;
    if (cmd.cap_pivot) pivot_r <= rdata;
    if (cmd.cap_i) ei_r <= rdata;
    if (cmd.cap_j) ej_r <= rdata;
    if (cmd.cap_res) res_r <= rdata;
    else if (cmd.err_res) res_r <= '0;
  end

  // fill count seen after this transfer's own element is stored
  logic [CW-1:0] fill_eff;
  assign fill_eff = (fill_r < CW'(DEPTH)) ? fill_r + CW'(1) : fill_r;

  assign sts.rank_bad   = (k_rank == '0) ||
                          ({{(KW+1-RANK_W){1'b0}}, k_rank} > (KW+1)'(fill_eff));
  assign sts.range_open = lo_r < hi_r;
  assign sts.i_less     = ei_r < pivot_r;
  assign sts.j_more     = ej_r > pivot_r;
  assign sts.i_lt_j     = i_r < j_r;
  assign res_value      = res_r;
endmodule
`default_nettype wire

// ===== rtl/core/kss_ctrl.sv =====
// selection sequencer state machine
`default_nettype none
module kss_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  output      logic              in_ready,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic              out_err,
  output      kss_pkg::kss_cmd_t cmd,
  input  wire kss_pkg::kss_sts_t sts
);
  import kss_pkg::*;

  kss_state_t state_r, state_nxt;
  logic err_r, err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            if (sts.rank_bad) begin
              cmd.err_res = 1'b1;
              err_nxt     = 1'b1;
              state_nxt   = ST_OUT;
            end else begin
              err_nxt   = 1'b0;
              state_nxt = ST_START;
            end
          end
        end
      end
      ST_START: begin
        cmd.start = 1'b1;
        state_nxt = ST_RANGE;
      end
      ST_RANGE: begin
        state_nxt = sts.range_open ? ST_PIV_RD : ST_FIN_RD;
      end
      ST_PIV_RD: begin
        cmd.rd_pivot = 1'b1;
        cmd.init_ij  = 1'b1;
        state_nxt    = ST_PIV_WT;
      end
      // read data is valid in the cycle after the read
      ST_PIV_WT: begin
        cmd.cap_pivot = 1'b1;
        state_nxt     = ST_I_RD;
      end
      ST_I_RD: begin
        cmd.rd_i  = 1'b1;
        state_nxt = ST_I_WT;
      end
      ST_I_WT: begin
        cmd.cap_i = 1'b1;
        state_nxt = ST_I_CMP;
      end
      ST_I_CMP: state_nxt = sts.i_less ? ST_I_RD : ST_J_RD;
      ST_J_RD: begin
        cmd.rd_j  = 1'b1;
        state_nxt = ST_J_WT;
      end
      ST_J_WT: begin
        cmd.cap_j = 1'b1;
        state_nxt = ST_J_CMP;
      end
      ST_J_CMP: begin
        if (sts.j_more) state_nxt = ST_J_RD;
        else if (sts.i_lt_j) state_nxt = ST_SWAP_I;
        else state_nxt = ST_NARROW;
      end
      ST_SWAP_I: begin
        cmd.wr_i  = 1'b1;
        state_nxt = ST_SWAP_J;
      end
      ST_SWAP_J: begin
        cmd.wr_j  = 1'b1;
        state_nxt = ST_I_RD;
      end
      ST_NARROW: begin
        cmd.narrow = 1'b1;
        state_nxt  = ST_RANGE;
      end
      ST_FIN_RD: begin
        cmd.rd_lo = 1'b1;
        state_nxt = ST_FIN_WT;
      end
      ST_FIN_WT: begin
        cmd.cap_res = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.clr_fill = 1'b1;
          state_nxt    = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  assign out_err = err_r;
endmodule
`default_nettype wire

// ===== rtl/core/kth_smallest_select_unit.sv =====
// top level of the k-th smallest select unit
`default_nettype none
// Loads signed 32-bit elements into a DEPTH-entry single-port store, one per
// transfer, one per cycle; elements past DEPTH are dropped. The transfer with
// in_last set closes the set: the unit then runs quickselect (Hoare partition
// around the middle element, narrowing to the side holding rank k) and emits
// one result, the k-th smallest value (k from cfg register, 1 = smallest) or 0
// with out_rank_error when k is 0 or above the number loaded. After a closing
// item, the partition scans read, wait for and compare each element visited,
// a swap writes both elements back, and each round adds a range check, pivot
// read, pivot capture and narrow; a start step and the result fetch come on
// top, all set by the one store port.
// Input is held off from the last transfer until the result transfer; a
// rank error skips the search and shows the result on the next cycle.
module kth_smallest_select_unit #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [kss_pkg::RANK_W-1:0] cfg_wdata,
  kss_in_if.sink                    in_ch,
  kss_out_if.source                 out_ch
);
  import kss_pkg::*;

  rank_t k_rank_r;
  kss_cmd_t cmd;
  kss_sts_t sts;
  data_t res_value;
  logic res_err;

  // rank register, reset to smallest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_rank_r <= RANK_W'(1);
    end else if (cfg_we) begin
      k_rank_r <= cfg_wdata;
    end
  end

  kss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.in_valid),
    .in_last  (in_ch.in_last),
    .in_ready (in_ch.in_ready),
    .out_valid(out_ch.out_valid),
    .out_ready(out_ch.out_ready),
    .out_err  (res_err),
    .cmd      (cmd),
    .sts      (sts)
  );

  kss_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_value (in_ch.in_value),
    .k_rank   (k_rank_r),
    .res_value(res_value)
  );

  // result register lives in the datapath
  assign out_ch.out_selected   = res_value;
  assign out_ch.out_rank_error = res_err;

`ifndef SYNTHESIS
  // never accept input while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.in_ready && out_ch.out_valid))
    else $error("input ready while result pending");

  // an error result always carries zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.out_valid && out_ch.out_rank_error) |-> (out_ch.out_selected == '0))
    else $error("rank error with nonzero value");

  // a result transfer returns the unit to loading
  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.out_valid && out_ch.out_ready) |=> in_ch.in_ready)
    else $error("not loading after result transfer");
`endif
endmodule
`default_nettype wire
